// File: rtl/segment_pair_intersection_assert.svh
// Assertion macros for the segment pair intersection RTL.
`ifndef SEGMENT_PAIR_INTERSECTION_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spi_pkg.sv
// Types, widths and helpers for the segment pair intersection pipeline.
package spi_pkg;

    localparam int COORD_BITS = 16;
    localparam int SW = COORD_BITS + 1;        // coordinate difference
    localparam int PW = 2 * COORD_BITS + 2;    // product of two differences
    localparam int DW = 2 * COORD_BITS + 4;    // cross term, numerator, denominator
    localparam int MW = 3 * COORD_BITS + 5;    // delta times numerator
    localparam int NW = 3 * COORD_BITS + 6;    // rounded dividend
    localparam int RW = 3 * COORD_BITS + 7;    // divider remainder
    localparam int QB = COORD_BITS + 1;        // quotient bits
    localparam int QW = QB + 1;                // signed quotient
    localparam int VW = COORD_BITS + 3;        // signed interpolated coordinate
    localparam int COORD_LAT = QB + 4;         // register stages in spi_coord

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t horiz_start_x;
        coord_t horiz_start_y;
        coord_t horiz_end_x;
        coord_t horiz_end_y;
        coord_t vert_start_x;
        coord_t vert_start_y;
        coord_t vert_end_x;
        coord_t vert_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        coord_t cross_x;
        coord_t cross_y;
    } cross_pt_t;

    typedef struct packed {
        logic valid;
        logic nohit;
    } stage_ctl_t;

    function automatic logic signed [SW-1:0] sdiff(coord_t a, coord_t b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

// File: rtl/spi_cross.sv
// Front stages: differences, cross products and the crossing fraction.
module spi_cross (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            item_valid,
    input  spi_pkg::seg_pair_t              item,
    output spi_pkg::stage_ctl_t             ctl,
    output logic [spi_pkg::DW-1:0]          den,
    output logic signed [spi_pkg::DW-1:0]   num,
    output spi_pkg::coord_t                 base_x,
    output spi_pkg::coord_t                 base_y,
    output logic signed [spi_pkg::SW-1:0]   delta_x,
    output logic signed [spi_pkg::SW-1:0]   delta_y,
    output spi_pkg::coord_t                 lo_x,
    output spi_pkg::coord_t                 hi_x,
    output spi_pkg::coord_t                 lo_y,
    output spi_pkg::coord_t                 hi_y
);

    // stage 1
    logic                           v1_reg;
    logic                           zero1_reg;
    logic signed [spi_pkg::SW-1:0]  dxh1_reg, dyh1_reg, a0_reg, b0_reg, a1_reg, b1_reg;
    logic signed [spi_pkg::SW-1:0]  dvx1_reg, dvy1_reg;
    spi_pkg::coord_t                vx1_reg, vy1_reg, hx0_1_reg, hx1_1_reg, vye1_reg;
    // stage 2
    logic                           v2_reg;
    logic                           zero2_reg;
    logic signed [spi_pkg::PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [spi_pkg::SW-1:0]  dvx2_reg, dvy2_reg;
    spi_pkg::coord_t                vx2_reg, vy2_reg, hx0_2_reg, hx1_2_reg, vye2_reg;
    // stage 3
    spi_pkg::stage_ctl_t            ctl_reg, ctl_next;
    logic [spi_pkg::DW-1:0]         den_reg, den_next;
    logic signed [spi_pkg::DW-1:0]  num_reg, num_next;
    logic signed [spi_pkg::SW-1:0]  dvx3_reg, dvy3_reg;
    spi_pkg::coord_t                vx3_reg, vy3_reg, hx0_3_reg, hx1_3_reg, vye3_reg;

    always_comb
    begin
        logic signed [spi_pkg::DW-1:0] d0;
        logic signed [spi_pkg::DW-1:0] d1;
        logic signed [spi_pkg::DW-1:0] dd;
        d0 = spi_pkg::DW'(p0_reg) - spi_pkg::DW'(p1_reg);
        d1 = spi_pkg::DW'(p2_reg) - spi_pkg::DW'(p3_reg);
        dd = d1 - d0;
        // keep the denominator positive, flip the numerator with it
        if (dd < 0)
        begin
            den_next = -dd;
            num_next = d0;
        end
        else
        begin
            den_next = dd;
            num_next = -d0;
        end
        ctl_next.valid = v2_reg;
        ctl_next.nohit = zero2_reg || (dd == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            ctl_reg.valid <= 1'b0;
            ctl_reg.nohit <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= item_valid;
            v2_reg  <= v1_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero1_reg <= (item.horiz_end_x == item.horiz_start_x);
            dxh1_reg  <= spi_pkg::sdiff(item.horiz_end_x, item.horiz_start_x);
            dyh1_reg  <= spi_pkg::sdiff(item.horiz_end_y, item.horiz_start_y);
            a0_reg    <= spi_pkg::sdiff(item.vert_start_y, item.horiz_start_y);
            b0_reg    <= spi_pkg::sdiff(item.vert_start_x, item.horiz_start_x);
            a1_reg    <= spi_pkg::sdiff(item.vert_end_y, item.horiz_start_y);
            b1_reg    <= spi_pkg::sdiff(item.vert_end_x, item.horiz_start_x);
            dvx1_reg  <= spi_pkg::sdiff(item.vert_end_x, item.vert_start_x);
            dvy1_reg  <= spi_pkg::sdiff(item.vert_end_y, item.vert_start_y);
            vx1_reg   <= item.vert_start_x;
            vy1_reg   <= item.vert_start_y;
            hx0_1_reg <= item.horiz_start_x;
            hx1_1_reg <= item.horiz_end_x;
            vye1_reg  <= item.vert_end_y;

            zero2_reg <= zero1_reg;
            p0_reg    <= a0_reg * dxh1_reg;
            p1_reg    <= dyh1_reg * b0_reg;
            p2_reg    <= a1_reg * dxh1_reg;
            p3_reg    <= dyh1_reg * b1_reg;
            dvx2_reg  <= dvx1_reg;
            dvy2_reg  <= dvy1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            hx0_2_reg <= hx0_1_reg;
            hx1_2_reg <= hx1_1_reg;
            vye2_reg  <= vye1_reg;

            den_reg   <= den_next;
            num_reg   <= num_next;
            dvx3_reg  <= dvx2_reg;
            dvy3_reg  <= dvy2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            hx0_3_reg <= hx0_2_reg;
            hx1_3_reg <= hx1_2_reg;
            vye3_reg  <= vye2_reg;
        end
    end

    assign ctl     = ctl_reg;
    assign den     = den_reg;
    assign num     = num_reg;
    assign base_x  = vx3_reg;
    assign base_y  = vy3_reg;
    assign delta_x = dvx3_reg;
    assign delta_y = dvy3_reg;
    assign lo_x    = hx0_3_reg;
    assign hi_x    = hx1_3_reg;
    assign lo_y    = vy3_reg;
    assign hi_y    = vye3_reg;

endmodule

// File: rtl/spi_coord.sv
// One coordinate: rounded interpolation through a bit-per-stage divider, then span test.
module spi_coord (
    input  logic                            clk,
    input  logic                            en,
    input  logic [spi_pkg::DW-1:0]          den,
    input  logic signed [spi_pkg::DW-1:0]   num,
    input  spi_pkg::coord_t                 base,
    input  logic signed [spi_pkg::SW-1:0]   delta,
    input  spi_pkg::coord_t                 lo,
    input  spi_pkg::coord_t                 hi,
    output logic                            in_range,
    output spi_pkg::coord_t                 value
);

    localparam int QB = spi_pkg::QB;

    // multiply stage
    logic signed [spi_pkg::MW-1:0]  p_reg;
    logic [spi_pkg::DW-1:0]         den4_reg;
    spi_pkg::coord_t                base4_reg, lo4_reg, hi4_reg;
    // dividend stage
    logic signed [spi_pkg::NW-1:0]  n_reg;
    logic [spi_pkg::DW:0]           d2_5_reg;
    spi_pkg::coord_t                base5_reg, lo5_reg, hi5_reg;
    // divider stages, index 0 is loaded by the magnitude stage
    logic [spi_pkg::RW-1:0]         rem_reg  [QB+1];
    logic [QB-1:0]                  quo_reg  [QB+1];
    logic [spi_pkg::DW:0]           d2_reg   [QB+1];
    logic                           neg_reg  [QB+1];
    logic                           ovf_reg  [QB+1];
    spi_pkg::coord_t                base_reg [QB+1];
    spi_pkg::coord_t                lo_reg   [QB+1];
    spi_pkg::coord_t                hi_reg   [QB+1];
    // result stage
    logic                           in_range_reg, in_range_next;
    spi_pkg::coord_t                value_reg, value_next;

    logic                           neg_next;
    logic [spi_pkg::RW-1:0]         mag_next;
    logic                           ovf_next;

    always_comb
    begin
        logic [spi_pkg::NW-1:0] n_abs;
        neg_next = n_reg[spi_pkg::NW-1];
        n_abs    = neg_next ? -n_reg : n_reg;
        // floor of a negative quotient: take the ceiling of the magnitude
        mag_next = spi_pkg::RW'(n_abs) +
                   (neg_next ? spi_pkg::RW'(d2_5_reg) - spi_pkg::RW'(1) : '0);
        ovf_next = mag_next >= (spi_pkg::RW'(d2_5_reg) << QB);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= spi_pkg::MW'(delta) * spi_pkg::MW'(num);
            den4_reg  <= den;
            base4_reg <= base;
            lo4_reg   <= lo;
            hi4_reg   <= hi;

            n_reg     <= $signed({p_reg, 1'b0}) +
                         $signed({{(spi_pkg::NW-spi_pkg::DW){1'b0}}, den4_reg});
            d2_5_reg  <= {den4_reg, 1'b0};
            base5_reg <= base4_reg;
            lo5_reg   <= lo4_reg;
            hi5_reg   <= hi4_reg;

            rem_reg[0]  <= mag_next;
            quo_reg[0]  <= '0;
            d2_reg[0]   <= d2_5_reg;
            neg_reg[0]  <= neg_next;
            ovf_reg[0]  <= ovf_next;
            base_reg[0] <= base5_reg;
            lo_reg[0]   <= lo5_reg;
            hi_reg[0]   <= hi5_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [spi_pkg::RW-1:0] shd;
        logic                   ge;
        assign shd = spi_pkg::RW'(d2_reg[k]) << (QB - 1 - k);
        assign ge  = rem_reg[k] >= shd;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? rem_reg[k] - shd : rem_reg[k];
                quo_reg[k+1]  <= quo_reg[k] | (QB'(ge) << (QB - 1 - k));
                d2_reg[k+1]   <= d2_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                base_reg[k+1] <= base_reg[k];
                lo_reg[k+1]   <= lo_reg[k];
                hi_reg[k+1]   <= hi_reg[k];
            end
        end
    end

    always_comb
    begin
        logic signed [spi_pkg::QW-1:0] q;
        logic signed [spi_pkg::VW-1:0] v;
        q = neg_reg[QB] ? -$signed({1'b0, quo_reg[QB]}) : $signed({1'b0, quo_reg[QB]});
        v = $signed({3'b000, base_reg[QB]}) + spi_pkg::VW'(q);
        in_range_next = !ovf_reg[QB] &&
                        (v >= $signed({3'b000, lo_reg[QB]})) &&
                        (v <= $signed({3'b000, hi_reg[QB]}));
        value_next = v[spi_pkg::COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_range_reg <= in_range_next;
            value_reg    <= value_next;
        end
    end

    assign in_range = in_range_reg;
    assign value    = value_reg;

endmodule

// File: rtl/segment_pair_intersection.sv
// Top level: segment pair intersection pipeline with output register.
//   channel | valid    | stall    | payload
//   input   | seg_valid| seg_stall| seg (spi_pkg::seg_pair_t)
//   output  | pt_valid | pt_stall | pt  (spi_pkg::cross_pt_t)
// One transaction per cycle while no finished result is held by pt_stall.
// The divider resolves one quotient bit per register stage.
// Reset clears only the valid and nohit control bits; payload registers carry no reset.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
`include "segment_pair_intersection_assert.svh"

module segment_pair_intersection (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   seg_valid,
    output logic                   seg_stall,
    input  spi_pkg::seg_pair_t     seg,
    output logic                   pt_valid,
    input  logic                   pt_stall,
    output spi_pkg::cross_pt_t     pt
);

    localparam int LAT = spi_pkg::COORD_LAT;

    logic                           en;
    spi_pkg::stage_ctl_t            ctl3;
    logic [spi_pkg::DW-1:0]         den;
    logic signed [spi_pkg::DW-1:0]  num;
    spi_pkg::coord_t                base_x, base_y, lo_x, hi_x, lo_y, hi_y;
    logic signed [spi_pkg::SW-1:0]  delta_x, delta_y;
    logic                           in_x, in_y;
    spi_pkg::coord_t                val_x, val_y;
    spi_pkg::stage_ctl_t            ctl_reg [LAT];
    logic                           pt_valid_reg;
    spi_pkg::cross_pt_t             pt_reg, pt_next;

    // advance unless a finished result is held
    assign en        = !(pt_valid_reg && pt_stall);
    assign seg_stall = !en;

    spi_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (seg_valid),
        .item       (seg),
        .ctl        (ctl3),
        .den        (den),
        .num        (num),
        .base_x     (base_x),
        .base_y     (base_y),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .lo_x       (lo_x),
        .hi_x       (hi_x),
        .lo_y       (lo_y),
        .hi_y       (hi_y)
    );

    spi_coord u_coord_x (
        .clk      (clk),
        .en       (en),
        .den      (den),
        .num      (num),
        .base     (base_x),
        .delta    (delta_x),
        .lo       (lo_x),
        .hi       (hi_x),
        .in_range (in_x),
        .value    (val_x)
    );

    spi_coord u_coord_y (
        .clk      (clk),
        .en       (en),
        .den      (den),
        .num      (num),
        .base     (base_y),
        .delta    (delta_y),
        .lo       (lo_y),
        .hi       (hi_y),
        .in_range (in_y),
        .value    (val_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
            pt_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl3;
            for (int i = 1; i < LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            pt_valid_reg <= ctl_reg[LAT-1].valid;
        end
    end

    always_comb
    begin
        pt_next.hit     = !ctl_reg[LAT-1].nohit && in_x && in_y;
        pt_next.cross_x = pt_next.hit ? val_x : '0;
        pt_next.cross_y = pt_next.hit ? val_y : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    `SPI_ASSERT_SAME(a_miss_zero, pt_valid && !pt.hit, pt.cross_x == '0 && pt.cross_y == '0, "miss with nonzero point")
    `SPI_ASSERT_SAME(a_stall_full, seg_stall, pt_valid && pt_stall, "input stalled without held result")
    `SPI_ASSERT_NEXT(a_freeze, pt_valid && pt_stall, $stable(ctl_reg[LAT-1].valid), "pipeline moved during stall")

endmodule

// File: test/tb_segment_pair_intersection.sv
// Testbench for the segment pair intersection pipeline: directed and random checks.
`timescale 1ns / 1ps

module tb_segment_pair_intersection;

    localparam int DRAIN_CYCLES = spi_pkg::COORD_BITS + 30;

    typedef logic signed [127:0] wide_t;

    logic               clk;
    logic               rst_n;
    logic               seg_valid;
    logic               seg_stall;
    spi_pkg::seg_pair_t seg;
    logic               pt_valid;
    logic               pt_stall;
    spi_pkg::cross_pt_t pt;

    spi_pkg::cross_pt_t expected_pts[$];
    int                 mismatches;
    bit                 stall_quiet;
    int                 stall_left;

    segment_pair_intersection dut (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
        .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic wide_t ext(spi_pkg::coord_t c);
        return wide_t'({112'd0, c});
    endfunction

    // floor(n / d) with d > 0
    function automatic wide_t floor_quot(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n < 0 && (n % d) != 0)
            q = q - 1;
        return q;
    endfunction

    function automatic spi_pkg::cross_pt_t predict_crossing(spi_pkg::seg_pair_t s);
        wide_t hx0, hy0, hx1, hy1, vx0, vy0, vx1, vy1;
        wide_t d0, d1, den, num, x, y;
        spi_pkg::cross_pt_t r;
        hx0 = ext(s.horiz_start_x);
        hy0 = ext(s.horiz_start_y);
        hx1 = ext(s.horiz_end_x);
        hy1 = ext(s.horiz_end_y);
        vx0 = ext(s.vert_start_x);
        vy0 = ext(s.vert_start_y);
        vx1 = ext(s.vert_end_x);
        vy1 = ext(s.vert_end_y);
        r = '0;
        if (hx1 == hx0)
            return r;
        d0 = (vy0 - hy0) * (hx1 - hx0) - (hy1 - hy0) * (vx0 - hx0);
        d1 = (vy1 - hy0) * (hx1 - hx0) - (hy1 - hy0) * (vx1 - hx0);
        den = d1 - d0;
        if (den == 0)
            return r;
        num = -d0;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        x = vx0 + floor_quot(2 * ((vx1 - vx0) * num) + den, 2 * den);
        y = vy0 + floor_quot(2 * ((vy1 - vy0) * num) + den, 2 * den);
        if (x >= hx0 && x <= hx1 && y >= vy0 && y <= vy1)
        begin
            r.hit = 1'b1;
            r.cross_x = x[spi_pkg::COORD_BITS-1:0];
            r.cross_y = y[spi_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    task automatic queue_expected(spi_pkg::cross_pt_t p);
        expected_pts = {expected_pts, p};
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_pair(spi_pkg::seg_pair_t s);
        int gap;
        seg <= s;
        seg_valid <= 1'b1;
        do
            @(posedge clk);
        while (seg_stall);
        queue_expected(predict_crossing(s));
        gap = pick_gap();
        if (gap > 0)
        begin
            seg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        seg_valid <= 1'b0;
        while (expected_pts.size() != 0)
            @(posedge clk);
    endtask

    function automatic spi_pkg::seg_pair_t make_pair(int hx0, int hy0, int hx1, int hy1,
                                                     int vx0, int vy0, int vx1, int vy1);
        spi_pkg::seg_pair_t s;
        s.horiz_start_x = spi_pkg::coord_t'(hx0);
        s.horiz_start_y = spi_pkg::coord_t'(hy0);
        s.horiz_end_x = spi_pkg::coord_t'(hx1);
        s.horiz_end_y = spi_pkg::coord_t'(hy1);
        s.vert_start_x = spi_pkg::coord_t'(vx0);
        s.vert_start_y = spi_pkg::coord_t'(vy0);
        s.vert_end_x = spi_pkg::coord_t'(vx1);
        s.vert_end_y = spi_pkg::coord_t'(vy1);
        return s;
    endfunction

    // Build a pair whose segments likely cross, with random local geometry.
    function automatic spi_pkg::seg_pair_t crossing_pair();
        int cx, cy, span;
        span = ($urandom_range(0, 9) == 0) ? 30000 : 400;
        cx = $urandom_range(span, 65535 - span);
        cy = $urandom_range(span, 65535 - span);
        return make_pair(cx - $urandom_range(1, span), cy + $urandom_range(0, span / 4)
                             - span / 8,
                         cx + $urandom_range(1, span), cy + $urandom_range(0, span / 4)
                             - span / 8,
                         cx + $urandom_range(0, span / 4) - span / 8,
                         cy - $urandom_range(0, span),
                         cx + $urandom_range(0, span / 4) - span / 8,
                         cy + $urandom_range(0, span));
    endfunction

    task automatic test_directed();
        send_pair(make_pair(0, 0, 65535, 65535, 0, 65535, 65535, 0));
        send_pair(make_pair(0, 0, 65535, 0, 0, 0, 0, 65535));
        send_pair(make_pair(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        // zero horizontal x extent
        send_pair(make_pair(100, 0, 100, 500, 50, 0, 150, 500));
        // parallel, then collinear
        send_pair(make_pair(0, 0, 100, 50, 0, 10, 100, 60));
        send_pair(make_pair(0, 0, 100, 50, 200, 100, 400, 200));
        // halfway ties: y = 0.5 on both slopes and y = 1.5 step off the line
        send_pair(make_pair(0, 0, 32, 16, 1, 0, 1, 100));
        send_pair(make_pair(0, 16, 32, 0, 31, 0, 31, 100));
        send_pair(make_pair(0, 0, 32, 16, 3, 0, 3, 100));
        // reversed horizontal span, reversed vertical span
        send_pair(make_pair(500, 100, 100, 100, 300, 0, 300, 200));
        send_pair(make_pair(100, 100, 500, 100, 300, 200, 300, 0));
        // crossing exactly at span ends
        send_pair(make_pair(100, 100, 500, 100, 100, 100, 100, 300));
        send_pair(make_pair(100, 100, 500, 100, 500, 0, 500, 100));
        // far crossing well outside the coordinate range, then two crossings inside it
        send_pair(make_pair(0, 0, 1, 65535, 65535, 0, 65534, 65535));
        send_pair(make_pair(0, 100, 65535, 101, 40000, 0, 40001, 65535));
        send_pair(make_pair(16, 32, 4096, 48, 2000, 16, 2010, 4000));
        wait_drained();
    endtask

    task automatic test_random_crossings(int count);
        for (int i = 0; i < count; i++)
            send_pair(crossing_pair());
    endtask

    task automatic test_random_noise(int count);
        spi_pkg::seg_pair_t s;
        for (int i = 0; i < count; i++)
        begin
            s = crossing_pair();
            case ($urandom_range(0, 3))
                0: s = {$urandom(), $urandom(), $urandom(), $urandom()};
                1: s.horiz_end_x = s.horiz_start_x;
                2: s = make_pair(s.horiz_end_x, s.horiz_start_y, s.horiz_start_x,
                                 s.horiz_end_y, s.vert_start_x, s.vert_start_y,
                                 s.vert_end_x, s.vert_end_y);
                default: s = make_pair(s.horiz_start_x, s.horiz_start_y, s.horiz_end_x,
                                       s.horiz_end_y, s.vert_end_x, s.vert_end_y,
                                       s.vert_start_x, s.vert_start_y);
            endcase
            send_pair(s);
        end
    endtask

    task automatic test_back_to_back(int count);
        stall_quiet = 1'b1;
        seg_valid <= 1'b1;
        for (int i = 0; i < count; i++)
        begin
            seg <= crossing_pair();
            do
                @(posedge clk);
            while (seg_stall);
            queue_expected(predict_crossing(seg));
        end
        wait_drained();
        stall_quiet = 1'b0;
    endtask

    // stall bursts: mostly short, a few long
    always @(posedge clk)
    begin
        int r;
        if (stall_quiet || !rst_n)
        begin
            stall_left = 0;
            pt_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pt_stall <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                pt_stall <= 1'b0;
            else
            begin
                pt_stall <= 1'b1;
                if (r < 96)
                    stall_left = $urandom_range(0, 2);
                else
                    stall_left = $urandom_range(7, 29);
            end
        end
    end

    always @(posedge clk)
    begin
        spi_pkg::cross_pt_t want;
        if (rst_n && pt_valid && !pt_stall)
        begin
            if (expected_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %h", pt);
            end
            else
            begin
                want = expected_pts.pop_front();
                if (pt.hit !== want.hit || pt.cross_x !== want.cross_x ||
                    pt.cross_y !== want.cross_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%b x=%h y=%h, got hit=%b x=%h y=%h",
                                 want.hit, want.cross_x, want.cross_y,
                                 pt.hit, pt.cross_x, pt.cross_y);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("segment_pair_intersection verification failed");
        $finish;
    end

    initial
    begin
        int guard;
        mismatches = 0;
        stall_quiet = 1'b0;
        rst_n = 1'b0;
        seg_valid = 1'b0;
        seg = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_crossings(400);
        wait_drained();
        test_back_to_back(60);
        test_random_noise(370);

        wait_drained();
        guard = 0;
        while (guard < DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        if (mismatches == 0 && expected_pts.size() == 0)
            $display("segment_pair_intersection verification clean");
        else
            $display("segment_pair_intersection verification failed");
        $finish;
    end

endmodule
